@@ src/tphi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tphi_pkg;
  localparam int DefDepth = 4096;
  localparam int DefComps = 6;
  localparam int NumComps = 6;
  localparam int StampW = 48;
  localparam int PoseW = 32;
  localparam int IdxW = 12;
  localparam logic [1:0] OpRecord = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [StampW-1:0] stamp;
    logic signed [PoseW-1:0] pose_c0;
    logic signed [PoseW-1:0] pose_c1;
    logic signed [PoseW-1:0] pose_c2;
    logic signed [PoseW-1:0] pose_c3;
    logic signed [PoseW-1:0] pose_c4;
    logic signed [PoseW-1:0] pose_c5;
  } req_t;

  typedef struct packed {
    logic signed [PoseW-1:0] out_c0;
    logic signed [PoseW-1:0] out_c1;
    logic signed [PoseW-1:0] out_c2;
    logic signed [PoseW-1:0] out_c3;
    logic signed [PoseW-1:0] out_c4;
    logic signed [PoseW-1:0] out_c5;
    logic no_history;
    logic [IdxW-1:0] found_index;
  } rsp_t;
endpackage
`default_nettype wire

@@ src/tphi_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tphi_lane
  import tphi_pkg::*;
(
  input  wire logic clk,
  input  wire logic start,
  input  wire logic interp,
  input  wire logic signed [PoseW-1:0] pa,
  input  wire logic signed [PoseW-1:0] pb,
  input  wire logic signed [18:0] frac,
  output logic signed [PoseW-1:0] res
);
  logic signed [PoseW:0] diff;
  logic signed [PoseW-1:0] pa_hold;
  logic signed [52:0] prod;
  logic signed [37:0] stepv;
  logic signed [38:0] sum;
  logic interp_hold;
  always_ff @(posedge clk) begin
    if (start) begin
      diff <= {pb[PoseW-1], pb} - {pa[PoseW-1], pa};
      pa_hold <= pa;
      interp_hold <= interp;
    end
    prod <= frac * diff + 53'sd32768;
  end
  always_comb begin
    stepv = {prod[52], prod[52:16]};
    sum = {{7{pa_hold[PoseW-1]}}, pa_hold} + {stepv[37], stepv};
    if (!interp_hold) res = pa_hold;
    else if (sum > 39'sd2147483647) res = 32'sh7fffffff;
    else if (sum < -39'sd2147483648) res = 32'sh80000000;
    else res = sum[PoseW-1:0];
  end
endmodule
`default_nettype wire

@@ src/tphi_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tphi_div
  import tphi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [StampW:0] num,
  input  wire logic signed [StampW:0] den,
  output logic busy,
  output logic signed [18:0] frac
);
  logic [StampW:0] num_abs, den_abs;
  logic [StampW:0] rem;
  logic [StampW-1:0] dv;
  logic [16:0] quo;
  logic [4:0] cnt;
  logic neg, sat;
  logic [StampW:0] sh;
  logic [StampW+1:0] trial;

  assign num_abs = num[StampW] ? -num : num;
  assign den_abs = den[StampW] ? -den : den;

  always_comb begin
    sh = (cnt == 5'd0) ? rem : {rem[StampW-1:0], 1'b0};
    trial = {1'b0, sh} - {2'b00, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'd0;
      rem <= num_abs;
      dv <= den_abs[StampW-1:0];
      neg <= num[StampW] ^ den[StampW];
      sat <= num_abs >= {den_abs[StampW-1:0], 1'b0};
      quo <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      rem <= trial[StampW+1] ? sh : trial[StampW:0];
      quo <= {quo[15:0], !trial[StampW+1]};
      if (cnt == 5'd16) busy <= 1'b0;
    end
  end

  always_comb begin
    if (sat) frac = neg ? -19'sd131072 : 19'sd131071;
    else if (neg) frac = -$signed({2'b00, quo});
    else frac = $signed({2'b00, quo});
  end
endmodule
`default_nettype wire

@@ src/timestamped_pose_history_interpolator.sv @@
// Channel | Dir | Handshake
// req     | in  | req_valid / req_ready
// rsp     | out | rsp_valid / rsp_ready
// Record and clear complete from the idle state. A query scans the stored stamps one
// entry at a time up to the first stamp not below the query, then runs a 17-step
// radix-2 fraction divider and two multiply stages (S_MUL, S_MUL2); without
// interpolation the divider is not started. Reset is synchronous and empties the ring.
// A stalled response holds in the output register; the next request waits for it.
`timescale 1ns / 1ps
`default_nettype none
module timestamped_pose_history_interpolator
  import tphi_pkg::*;
#(
  parameter int HISTORY_DEPTH = DefDepth,
  parameter int POSE_COMPONENTS = DefComps
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic req_ready,
  input  wire req_t req,
  output logic rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t rsp
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_RDA = 4'd2, S_WA = 4'd3,
    S_RDB = 4'd4, S_WB = 4'd5, S_DIV = 4'd6, S_DW = 4'd7, S_MUL = 4'd8,
    S_MUL2 = 4'd9, S_OUT = 4'd10;
  logic [3:0] state;
  logic [StampW-1:0] stamp_mem [HISTORY_DEPTH];
  logic [NumComps*PoseW-1:0] pose_mem [HISTORY_DEPTH];
  logic [AW-1:0] oldest;
  logic [CW-1:0] count, id;
  logic [StampW-1:0] q, rd_stamp, ta;
  logic [NumComps*PoseW-1:0] rd_pose, pa_v, pb_v;
  logic [AW-1:0] raddr;
  logic scan_wait, interp, interp_now, div_start, lane_start;
  logic signed [18:0] frac;
  logic div_busy;
  logic signed [StampW:0] num, den;
  logic signed [PoseW-1:0] lres [NumComps];
  logic [NumComps*PoseW-1:0] wpose;
  logic [AW-1:0] wslot;
  logic [CW:0] psum;

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] d;
    d = (s >= (CW+1)'(HISTORY_DEPTH)) ? s - (CW+1)'(HISTORY_DEPTH) : s;
    return d[AW-1:0];
  endfunction

  assign req_ready = (state == S_IDLE) && !rsp_valid;
  assign wpose = {req.pose_c5, req.pose_c4, req.pose_c3, req.pose_c2, req.pose_c1,
                  req.pose_c0};
  assign psum = {1'b0, oldest} + {1'b0, count};
  assign wslot = (count >= CW'(HISTORY_DEPTH)) ? oldest : wrap(psum);

  always_ff @(posedge clk) begin
    if (req_valid && req_ready && req.op == OpRecord) begin
      stamp_mem[wslot] <= req.stamp;
      pose_mem[wslot] <= wpose;
    end
    rd_stamp <= stamp_mem[raddr];
    rd_pose <= pose_mem[raddr];
  end

  always_comb begin
    raddr = wrap({1'b0, oldest} + {1'b0, id});
    if (state == S_RDB) raddr = wrap({1'b0, oldest} + {1'b0, id} + 1'b1);
  end

  assign num = $signed({1'b0, q}) - $signed({1'b0, ta});
  assign den = $signed({1'b0, rd_stamp}) - $signed({1'b0, ta});

  tphi_div u_div (.clk, .rst, .start(div_start), .num, .den, .busy(div_busy), .frac);

  for (genvar g = 0; g < NumComps; g++) begin : g_lane
    tphi_lane u_lane (.clk, .start(lane_start), .interp,
      .pa(pa_v[g*PoseW +: PoseW]), .pb(pb_v[g*PoseW +: PoseW]), .frac,
      .res(lres[g]));
  end

  assign interp_now = (id + 1'b1 < count) && (rd_stamp != ta);
  assign div_start = (state == S_WB) && interp_now;
  assign lane_start = (state == S_DW) && !div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      oldest <= '0;
      count <= '0;
      rsp_valid <= 1'b0;
      scan_wait <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req_valid && req_ready) begin
          q <= req.stamp;
          id <= '0;
          scan_wait <= 1'b1;
          if (req.op == OpRecord) begin
            if (count >= CW'(HISTORY_DEPTH)) oldest <= wrap({2'b00, oldest} + (CW+1)'(1));
            else count <= count + 1'b1;
          end else if (req.op == OpClear) begin
            count <= '0;
            oldest <= '0;
          end else if (req.op == OpQuery) begin
            if (count == '0) begin
              rsp <= {{(NumComps*PoseW){1'b0}}, 1'b1, {IdxW{1'b0}}};
              rsp_valid <= 1'b1;
            end else state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_wait <= !scan_wait;
          if (!scan_wait) begin
            if (id < count && rd_stamp < q) id <= id + 1'b1;
            else begin
              if (id != '0) id <= id - 1'b1;
              state <= S_RDA;
            end
          end
        end
        S_RDA: state <= S_WA;
        S_WA: state <= S_RDB;
        S_RDB: begin
          ta <= rd_stamp;
          pa_v <= rd_pose;
          state <= S_WB;
        end
        S_WB: begin
          pb_v <= rd_pose;
          interp <= interp_now;
          state <= S_DIV;
        end
        S_DIV: state <= S_DW;
        S_DW: if (!div_busy) state <= S_MUL;
        S_MUL: state <= S_MUL2;
        S_MUL2: state <= S_OUT;
        S_OUT: begin
          rsp.out_c0 <= lres[0];
          rsp.out_c1 <= (POSE_COMPONENTS > 1) ? lres[1] : '0;
          rsp.out_c2 <= (POSE_COMPONENTS > 2) ? lres[2] : '0;
          rsp.out_c3 <= (POSE_COMPONENTS > 3) ? lres[3] : '0;
          rsp.out_c4 <= (POSE_COMPONENTS > 4) ? lres[4] : '0;
          rsp.out_c5 <= (POSE_COMPONENTS > 5) ? lres[5] : '0;
          rsp.no_history <= 1'b0;
          rsp.found_index <= IdxW'(id);
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/tphi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tphi_checker
  import tphi_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("rsp dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("ready while response pending");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.no_history |-> rsp.found_index == '0) else $error("bad empty");
  a_acc: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !rsp_valid) else $error("request taken while busy");
endmodule
bind timestamped_pose_history_interpolator tphi_checker u_chk (.clk, .rst, .req_valid,
  .req_ready, .rsp_valid, .rsp_ready, .rsp);
`default_nettype wire

@@ tb/sv/tb_timestamped_pose_history_interpolator.sv @@
`timescale 1ns / 1ps
module tb_timestamped_pose_history_interpolator;
  import tphi_pkg::*;

  localparam int Depth = 4096;
  localparam int WatchLimit = 60000;
  localparam int RandomItems = 1830;
  localparam logic [1:0] OpSpare = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  always #6 clk = ~clk;

  timestamped_pose_history_interpolator DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  req_t pending_reqs[$];
  rsp_t expected_poses[$];
  logic [StampW-1:0] hist_stamp[Depth];
  logic signed [PoseW-1:0] hist_pose[Depth][NumComps];
  int unsigned head_ptr = 0;
  int unsigned fill_cnt = 0;
  int mismatches = 0;
  int send_gap = 0;
  int ready_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int pose_count = 0;
  int idle_cycles = 0;

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned slot_of(int unsigned logical);
    return (head_ptr + logical) % Depth;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint frac_q216(longint num, longint den);
    logic [63:0] un, ud, qt;
    bit neg;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    qt = (un << 16) / ud;
    if (neg) return (qt >= 64'd131072) ? -64'sd131072 : -longint'(qt);
    return (qt > 64'd131071) ? 64'sd131071 : longint'(qt);
  endfunction

  task automatic apply_request(req_t r);
    rsp_t e;
    longint res[NumComps];
    logic signed [PoseW-1:0] comps[NumComps];
    int unsigned id, a, b, slot;
    longint ta, tb, num, den, f, d, st;
    comps = '{r.pose_c0, r.pose_c1, r.pose_c2, r.pose_c3, r.pose_c4, r.pose_c5};
    case (r.op)
      OpRecord: begin
        if (fill_cnt >= Depth) begin
          slot = head_ptr;
          head_ptr = (head_ptr + 1) % Depth;
        end else begin
          slot = slot_of(fill_cnt);
          fill_cnt++;
        end
        hist_stamp[slot] = r.stamp;
        for (int c = 0; c < NumComps; c++) hist_pose[slot][c] = comps[c];
      end
      OpClear: begin
        fill_cnt = 0;
        head_ptr = 0;
      end
      OpQuery: begin
        e = '0;
        if (fill_cnt == 0) begin
          e.no_history = 1'b1;
        end else begin
          id = 0;
          while (id < fill_cnt && hist_stamp[slot_of(id)] < r.stamp) id++;
          if (id != 0) id--;
          a = slot_of(id);
          for (int c = 0; c < NumComps; c++) res[c] = hist_pose[a][c];
          if (id + 1 < fill_cnt) begin
            b = slot_of(id + 1);
            ta = longint'({16'd0, hist_stamp[a]});
            tb = longint'({16'd0, hist_stamp[b]});
            num = longint'({16'd0, r.stamp}) - ta;
            den = tb - ta;
            if (den != 0) begin
              f = frac_q216(num, den);
              for (int c = 0; c < NumComps; c++) begin
                d = longint'(hist_pose[b][c]) - longint'(hist_pose[a][c]);
                st = (f * d + 64'sd32768) >>> 16;
                res[c] = sat32(longint'(hist_pose[a][c]) + st);
              end
            end
          end
          e.out_c0 = res[0][31:0];
          e.out_c1 = res[1][31:0];
          e.out_c2 = res[2][31:0];
          e.out_c3 = res[3][31:0];
          e.out_c4 = res[4][31:0];
          e.out_c5 = res[5][31:0];
          e.found_index = id[IdxW-1:0];
        end
        expected_poses = {expected_poses, e};
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) apply_request(req);
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs[0];
          pending_reqs.delete(0);
          req_valid <= 1'b1;
          send_gap = next_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        pose_count++;
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", rsp);
        end else begin
          e = expected_poses[0];
          expected_poses.delete(0);
          if (rsp !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: expected %h got %h", e, rsp);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!hold_done && pose_count == 300) begin
        hold_done = 1;
        hold_left = 3000;
        rsp_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        ready_gap = next_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [StampW-1:0] rand_stamp();
    return StampW'({$urandom(), $urandom()});
  endfunction

  function automatic logic signed [PoseW-1:0] rand_pose();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return $urandom_range(0, 2097152) - 1048576;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_record(logic [StampW-1:0] t);
    req_t r;
    r.op = OpRecord;
    r.stamp = t;
    r.pose_c0 = rand_pose();
    r.pose_c1 = rand_pose();
    r.pose_c2 = rand_pose();
    r.pose_c3 = rand_pose();
    r.pose_c4 = rand_pose();
    r.pose_c5 = rand_pose();
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic add_plain(logic [1:0] op, logic [StampW-1:0] t);
    req_t r;
    r = req_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom()});
    r.op = op;
    r.stamp = t;
    pending_reqs = {pending_reqs, r};
  endtask

  initial begin
    logic [StampW-1:0] t, base;
    int n, items;
    // Directed part: empty ring, extremes, equal stamps, both ends of the range.
    add_plain(OpQuery, 48'd1000);
    add_plain(OpSpare, 48'hFFFFFFFFFFFF);
    add_record(48'd0);
    add_plain(OpQuery, 48'd0);
    add_plain(OpQuery, 48'hFFFFFFFFFFFF);
    add_record(48'd5000);
    add_plain(OpQuery, 48'd2500);
    add_plain(OpQuery, 48'd9000);
    add_plain(OpClear, 48'd0);
    add_record(48'd100000);
    add_record(48'd100001);
    add_plain(OpQuery, 48'd0);
    add_plain(OpQuery, 48'd100000);
    add_record(48'd100001);
    add_plain(OpQuery, 48'd100001);
    add_record(48'hFFFFFFFFFFFF);
    add_plain(OpQuery, 48'hFFFFFFFFFFFE);
    add_plain(OpQuery, 48'hFFFFFFFFFFFF);
    add_record(48'd7);
    add_plain(OpQuery, 48'd50);
    add_plain(OpClear, 48'hFFFFFFFFFFFF);
    add_plain(OpQuery, 48'd3);
    items = 0;
    while (items < RandomItems) begin
      add_plain(OpClear, rand_stamp());
      items++;
      base = ($urandom_range(0, 3) == 0) ? rand_stamp() : StampW'($urandom_range(0, 100000));
      t = base;
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) t = rand_stamp();
        else if ($urandom_range(0, 4) != 0) t = t + StampW'($urandom_range(0, 2000));
        add_record(t);
        items++;
        if ($urandom_range(0, 3) == 0) begin
          add_plain(OpQuery, t - StampW'($urandom_range(0, 3000)));
          items++;
        end
      end
      n = $urandom_range(2, 6);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: add_plain(OpQuery, rand_stamp());
          1: add_plain(OpQuery, base - StampW'($urandom_range(0, 100000)));
          2: add_plain(OpQuery, t + StampW'($urandom_range(0, 3000)));
          3: add_plain(OpSpare, rand_stamp());
          default: add_plain(OpQuery, base + StampW'($urandom_range(0, 32'(t - base + 1))));
        endcase
        items++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() > 0 || req_valid) @(posedge clk);
    while (expected_poses.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ timestamped_pose_history_interpolator.f @@
src/tphi_pkg.sv
src/tphi_lane.sv
src/tphi_div.sv
src/timestamped_pose_history_interpolator.sv
src/tphi_checker.sv
tb/sv/tb_timestamped_pose_history_interpolator.sv
